/* hw/rtl/rrs_pkg.sv */
// Widths, payload types and sequencer states shared by the running RTT statistics block.
package rrs_pkg;

	localparam int unsigned RttW   = 32;
	localparam int unsigned FracW  = 16;
	localparam int unsigned MeanW  = 48;
	localparam int unsigned VarW   = 64;
	localparam int unsigned CountW = 32;

	// Width of the shared adder and of the two working registers around it
	localparam int unsigned AluW   = 67;
	localparam int unsigned StepW  = 7;

	// Iterations of each bit-serial phase
	localparam int unsigned MulMeanSteps = CountW;
	localparam int unsigned DivMeanSteps = MeanW;
	localparam int unsigned MulVarSteps  = MeanW;
	localparam int unsigned DivVarSteps  = AluW;

	typedef logic [RttW-1:0]   rtt_t;
	typedef logic [MeanW-1:0]  mean_t;
	typedef logic [VarW-1:0]   var_t;
	typedef logic [CountW-1:0] count_t;
	typedef logic [AluW-1:0]   alu_t;
	typedef logic [StepW-1:0]  step_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_MEAN,
		ST_MEAN_LD,
		ST_DIV_MEAN,
		ST_VAR_PREP,
		ST_MUL_VAR,
		ST_VAR_DIFF,
		ST_VAR_ABS,
		ST_DIV_VAR,
		ST_VAR_UPD,
		ST_FINISH
	} seq_state_t;

endpackage

/* hw/rtl/rrs_if.sv */
// Request channels of the running RTT statistics block: sample in, statistics out.
interface rrs_sample_if;
	logic         valid;
	logic         ready;
	rrs_pkg::rtt_t rtt_us;

	modport source (output valid, output rtt_us, input ready);
	modport sink   (input valid, input rtt_us, output ready);
endinterface

interface rrs_stats_if;
	logic            valid;
	logic            ready;
	rrs_pkg::rtt_t   min_us;
	rrs_pkg::rtt_t   max_us;
	rrs_pkg::mean_t  mean_q16;
	rrs_pkg::var_t   variance_us2;
	rrs_pkg::count_t sample_count;

	modport source (output valid, output min_us, output max_us, output mean_q16,
		output variance_us2, output sample_count, input ready);
	modport sink   (input valid, input min_us, input max_us, input mean_q16,
		input variance_us2, input sample_count, output ready);
endinterface

/* hw/rtl/running_rtt_statistics.sv */
// Running RTT statistics: min, max, mean and Welford sample variance over a sample stream.
//
// Each request on the sample channel carries one round-trip time in whole microseconds and
// produces exactly one request on the stats channel with the minimum, maximum, Q32.16 mean,
// sample variance in whole us^2 (clamped at zero, saturating at all ones) and the sample
// count (saturating). All multiplies, divides and variance sums run through one 67-bit
// add/subtract unit driven by a small sequencer, one bit per cycle: a 32-step shift-add
// multiply forms count*mean+sample, a 48-step restoring divide by count+1 yields the new
// mean, a 48-step multiply forms the product of the two mean deviations and a 67-step
// restoring divide by the old count scales the variance correction. A sample occupies the
// block from acceptance until the sequencer returns to idle; it passes through ST_VAR_ABS
// as well when both deviations share a sign and their product falls below the stored
// variance, and the first sample after reset skips the variance phases. The statistics
// registers double as the output register: the next sample is accepted while a result
// still waits, and the final write-back holds only until that result has been taken.
module running_rtt_statistics (
	input logic          clk,
	input logic          arst_n,
	rrs_sample_if.sink   sample,
	rrs_stats_if.source  stats
);

	localparam int unsigned MulPad  = rrs_pkg::AluW - rrs_pkg::MeanW;
	localparam int unsigned CntPad  = rrs_pkg::AluW - rrs_pkg::CountW;
	localparam int unsigned VarPad  = rrs_pkg::AluW - rrs_pkg::VarW;
	localparam int unsigned RemW    = rrs_pkg::CountW + 1;
	localparam int unsigned LowW    = rrs_pkg::MeanW - rrs_pkg::CountW;
	localparam int unsigned PTailW  = rrs_pkg::VarW - rrs_pkg::MeanW;

	rrs_pkg::seq_state_t state_q, state_d;
	rrs_pkg::step_t      step_q;

	// Working pair around the shared adder: product or remainder high, multiplier or quotient low
	rrs_pkg::alu_t       hi_q, lo_q;

	rrs_pkg::rtt_t       x_q;
	rrs_pkg::mean_t      m1_q, m2_q, mnew_q;
	logic                s1_q, s2_q, dneg_q;
	logic [RemW-1:0]     dvs_q;

	// Statistics stores, also presented on the stats channel
	rrs_pkg::rtt_t       min_q, max_q;
	rrs_pkg::mean_t      mean_q;
	rrs_pkg::var_t       var_q;
	rrs_pkg::count_t     count_q;
	logic                ov_q;

	logic                accept;
	logic                fin_ld;
	logic                step_last;

	rrs_pkg::alu_t       alu_a, alu_b, alu_bx, alu_res;
	logic                alu_sub;

	rrs_pkg::alu_t       mul_t;
	rrs_pkg::alu_t       div_shift;
	logic                div_ok;

	rrs_pkg::mean_t      xin_q16, xs_q16, quot_mean;
	logic                s1_in, s2_new;
	rrs_pkg::mean_t      m1_in, m2_new;
	rrs_pkg::var_t       pmag;
	rrs_pkg::var_t       vnew;
	logic                dev_opp;

	// ------------------------------------------------------------------------------------
	// Handshake and channel payload
	// ------------------------------------------------------------------------------------
	assign accept    = sample.valid && sample.ready;
	assign fin_ld    = (state_q == rrs_pkg::ST_FINISH) && (!ov_q || stats.ready);
	assign step_last = (step_q == '0);

	assign stats.valid        = ov_q;
	assign stats.min_us       = min_q;
	assign stats.max_us       = max_q;
	assign stats.mean_q16     = mean_q;
	assign stats.variance_us2 = var_q;
	assign stats.sample_count = count_q;

	// ------------------------------------------------------------------------------------
	// Deviation magnitudes and signs, in Q32.16
	// ------------------------------------------------------------------------------------
	assign xin_q16   = {sample.rtt_us, {rrs_pkg::FracW{1'b0}}};
	assign xs_q16    = {x_q, {rrs_pkg::FracW{1'b0}}};
	assign quot_mean = lo_q[rrs_pkg::MeanW-1:0];

	assign s1_in  = xin_q16 < mean_q;
	assign m1_in  = s1_in ? (mean_q - xin_q16) : (xin_q16 - mean_q);
	assign s2_new = xs_q16 < quot_mean;
	assign m2_new = s2_new ? (quot_mean - xs_q16) : (xs_q16 - quot_mean);

	// Deviations of opposite sign make the product negative
	assign dev_opp = s1_q ^ s2_q;

	// Product of the deviations, Q64.32 truncated to whole us^2
	assign pmag = {hi_q[rrs_pkg::MeanW-1:0], lo_q[rrs_pkg::AluW-1 -: PTailW]};

	// ------------------------------------------------------------------------------------
	// Shared add/subtract unit and its step helpers
	// ------------------------------------------------------------------------------------
	assign alu_bx  = alu_sub ? ~alu_b : alu_b;
	assign alu_res = alu_a + alu_bx + {{(rrs_pkg::AluW-1){1'b0}}, alu_sub};

	// Shift-add multiply: add the multiplicand when the multiplier bit is set
	assign mul_t = lo_q[0] ? alu_res : hi_q;

	// Restoring divide: keep the difference when it did not borrow
	assign div_shift = {hi_q[rrs_pkg::AluW-2:0], lo_q[rrs_pkg::AluW-1]};
	assign div_ok    = !alu_res[rrs_pkg::AluW-1];

	// Clamp the updated variance at zero and at all ones
	always_comb begin
		if (dneg_q) begin
			vnew = alu_res[rrs_pkg::AluW-1] ? '0 : alu_res[rrs_pkg::VarW-1:0];
		end else begin
			vnew = (|alu_res[rrs_pkg::AluW-1:rrs_pkg::VarW]) ? '1 : alu_res[rrs_pkg::VarW-1:0];
		end
	end

	// ------------------------------------------------------------------------------------
	// Sequencer: next state
	// ------------------------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			rrs_pkg::ST_IDLE: begin
				if (accept) state_d = rrs_pkg::ST_MUL_MEAN;
			end
			rrs_pkg::ST_MUL_MEAN: begin
				if (step_last) state_d = rrs_pkg::ST_MEAN_LD;
			end
			rrs_pkg::ST_MEAN_LD: begin
				state_d = rrs_pkg::ST_DIV_MEAN;
			end
			rrs_pkg::ST_DIV_MEAN: begin
				if (step_last) state_d = rrs_pkg::ST_VAR_PREP;
			end
			rrs_pkg::ST_VAR_PREP: begin
				// The first sample sets the variance to zero: skip the variance phases
				state_d = (count_q == '0) ? rrs_pkg::ST_FINISH : rrs_pkg::ST_MUL_VAR;
			end
			rrs_pkg::ST_MUL_VAR: begin
				if (step_last) state_d = rrs_pkg::ST_VAR_DIFF;
			end
			rrs_pkg::ST_VAR_DIFF: begin
				if (!dev_opp && alu_res[rrs_pkg::AluW-1]) begin
					state_d = rrs_pkg::ST_VAR_ABS;
				end else begin
					state_d = rrs_pkg::ST_DIV_VAR;
				end
			end
			rrs_pkg::ST_VAR_ABS: begin
				state_d = rrs_pkg::ST_DIV_VAR;
			end
			rrs_pkg::ST_DIV_VAR: begin
				if (step_last) state_d = rrs_pkg::ST_VAR_UPD;
			end
			rrs_pkg::ST_VAR_UPD: begin
				state_d = rrs_pkg::ST_FINISH;
			end
			rrs_pkg::ST_FINISH: begin
				if (fin_ld) state_d = rrs_pkg::ST_IDLE;
			end
			default: begin
				state_d = rrs_pkg::ST_IDLE;
			end
		endcase
	end

	// ------------------------------------------------------------------------------------
	// Sequencer: outputs (ready and the operands of the shared unit)
	// ------------------------------------------------------------------------------------
	always_comb begin
		sample.ready = (state_q == rrs_pkg::ST_IDLE);
		alu_a        = hi_q;
		alu_b        = '0;
		alu_sub      = 1'b0;
		case (state_q)
			rrs_pkg::ST_MUL_MEAN: begin
				alu_a = hi_q;
				alu_b = {{MulPad{1'b0}}, mean_q};
			end
			rrs_pkg::ST_DIV_MEAN: begin
				alu_a   = div_shift;
				alu_b   = {{(rrs_pkg::AluW-RemW){1'b0}}, dvs_q};
				alu_sub = 1'b1;
			end
			rrs_pkg::ST_MUL_VAR: begin
				alu_a = hi_q;
				alu_b = {{MulPad{1'b0}}, m2_q};
			end
			rrs_pkg::ST_VAR_DIFF: begin
				// Negative product: the difference is -(P + V), keep its magnitude
				alu_a   = {{VarPad{1'b0}}, pmag};
				alu_b   = {{VarPad{1'b0}}, var_q};
				alu_sub = !dev_opp;
			end
			rrs_pkg::ST_VAR_ABS: begin
				alu_a   = '0;
				alu_b   = lo_q;
				alu_sub = 1'b1;
			end
			rrs_pkg::ST_DIV_VAR: begin
				alu_a   = div_shift;
				alu_b   = {{CntPad{1'b0}}, count_q};
				alu_sub = 1'b1;
			end
			rrs_pkg::ST_VAR_UPD: begin
				alu_a   = {{VarPad{1'b0}}, var_q};
				alu_b   = lo_q;
				alu_sub = dneg_q;
			end
			default: begin
				alu_a   = hi_q;
				alu_b   = '0;
				alu_sub = 1'b0;
			end
		endcase
	end

	// ------------------------------------------------------------------------------------
	// Control registers
	// ------------------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rrs_pkg::ST_IDLE;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (fin_ld) begin
				ov_q <= 1'b1;
			end else if (stats.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// Statistics stores: write back only once the previous result has been taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q   <= '1;
			max_q   <= '0;
			mean_q  <= '0;
			var_q   <= '0;
			count_q <= '0;
		end else if (fin_ld) begin
			if (x_q < min_q) min_q <= x_q;
			if (x_q > max_q) max_q <= x_q;
			mean_q <= mnew_q;
			var_q  <= (count_q == '0) ? '0 : hi_q[rrs_pkg::VarW-1:0];
			if (count_q != '1) count_q <= count_q + 1'b1;
		end
	end

	// ------------------------------------------------------------------------------------
	// Datapath registers
	// ------------------------------------------------------------------------------------
	always_ff @(posedge clk) begin
		case (state_q)
			rrs_pkg::ST_IDLE: begin
				if (accept) begin
					// Seed the high half with the sample so the multiply yields n*M + X
					x_q    <= sample.rtt_us;
					s1_q   <= s1_in;
					m1_q   <= m1_in;
					hi_q   <= {{MulPad{1'b0}}, xin_q16};
					lo_q   <= {{CntPad{1'b0}}, count_q};
					step_q <= rrs_pkg::step_t'(rrs_pkg::MulMeanSteps - 1);
				end
			end
			rrs_pkg::ST_MUL_MEAN, rrs_pkg::ST_MUL_VAR: begin
				hi_q   <= {1'b0, mul_t[rrs_pkg::AluW-1:1]};
				lo_q   <= {mul_t[0], lo_q[rrs_pkg::AluW-1:1]};
				step_q <= step_q - 1'b1;
			end
			rrs_pkg::ST_MEAN_LD: begin
				// Top bits of the sum are below count+1: start the remainder with them
				hi_q   <= {{(rrs_pkg::AluW-RemW){1'b0}},
					hi_q[rrs_pkg::MeanW:LowW]};
				lo_q   <= {hi_q[LowW-1:0], lo_q[rrs_pkg::AluW-1 -: rrs_pkg::CountW],
					{MulPad{1'b0}}};
				dvs_q  <= {1'b0, count_q} + 1'b1;
				step_q <= rrs_pkg::step_t'(rrs_pkg::DivMeanSteps - 1);
			end
			rrs_pkg::ST_DIV_MEAN, rrs_pkg::ST_DIV_VAR: begin
				hi_q   <= div_ok ? alu_res : div_shift;
				lo_q   <= {lo_q[rrs_pkg::AluW-2:0], div_ok};
				step_q <= step_q - 1'b1;
			end
			rrs_pkg::ST_VAR_PREP: begin
				mnew_q <= quot_mean;
				s2_q   <= s2_new;
				m2_q   <= m2_new;
				hi_q   <= '0;
				lo_q   <= {{MulPad{1'b0}}, m1_q};
				step_q <= rrs_pkg::step_t'(rrs_pkg::MulVarSteps - 1);
			end
			rrs_pkg::ST_VAR_DIFF: begin
				hi_q   <= '0;
				lo_q   <= alu_res;
				dneg_q <= dev_opp || alu_res[rrs_pkg::AluW-1];
				step_q <= rrs_pkg::step_t'(rrs_pkg::DivVarSteps - 1);
			end
			rrs_pkg::ST_VAR_ABS: begin
				lo_q   <= alu_res;
			end
			rrs_pkg::ST_VAR_UPD: begin
				hi_q   <= {{VarPad{1'b0}}, vnew};
			end
			default: begin
				hi_q   <= hi_q;
			end
		endcase
	end

	// ------------------------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------------------------

	// A result never shows up the cycle after a sample was taken
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !$rose(stats.valid))
		else $error("stats valid rose right after a sample was accepted");

	// A fresh result always reflects at least one sample with consistent extremes
	a_fresh_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(stats.valid) |-> (stats.sample_count != '0) && (stats.min_us <= stats.max_us))
		else $error("fresh result has zero count or min above max");

	// The running mean stays between the extremes
	a_mean_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		stats.valid |-> (stats.mean_q16 >= {stats.min_us, {rrs_pkg::FracW{1'b0}}}) &&
			(stats.mean_q16 <= {stats.max_us, {rrs_pkg::FracW{1'b0}}}))
		else $error("mean outside the min/max range");

	// The first sample leaves a zero variance
	a_first_var_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(stats.valid && (stats.sample_count == rrs_pkg::count_t'(1))) |->
			(stats.variance_us2 == '0))
		else $error("variance nonzero after the first sample");

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the running RTT statistics block: random samples, stalls, checks.
module tb_top;

	// Allow a generous margin after the last expected request before the final verdict.
	localparam int unsigned DrainCycles     = 250;
	localparam int unsigned RandomSamples   = 730;
	localparam int unsigned PressureSamples = 8;
	localparam int unsigned HoldCycles      = 1500;
	// Worst case per sample: the busy time, the longest sender gap and the longest receiver
	// stall, over roughly 760 samples, then taken several times over.
	localparam int unsigned CycleLimit      = 3_000_000;

	typedef struct packed {
		rrs_pkg::rtt_t   min_us;
		rrs_pkg::rtt_t   max_us;
		rrs_pkg::mean_t  mean_q16;
		rrs_pkg::var_t   variance_us2;
		rrs_pkg::count_t sample_count;
	} rtt_stats_t;

	logic clk;
	logic arst_n;

	rrs_sample_if sample_ch ();
	rrs_stats_if  stats_ch ();

	running_rtt_statistics dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.stats  (stats_ch)
	);

	// Statistics expected on the output channel, oldest first.
	rtt_stats_t expected_stats_q[$];
	int unsigned error_count = 0;

	// Running statistics as the block should hold them, starting from the reset values.
	rrs_pkg::rtt_t   min_seen   = '1;
	rrs_pkg::rtt_t   max_seen   = '0;
	rrs_pkg::mean_t  mean_acc   = '0;
	rrs_pkg::var_t   var_acc    = '0;
	rrs_pkg::count_t count_seen = '0;

	// Set by the test tasks: suppress random gaps and stalls for a stretch.
	bit          steady_flow = 1'b0;
	// Pulse to start the long receiver hold-off, counted down from HoldCycles.
	logic        hold_start  = 1'b0;
	int unsigned hold_left   = 0;
	int unsigned cycle_count = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Advance the running statistics by one sample and return what the block must report.
	// The mean update is exact at full width; the variance correction uses signed division,
	// which truncates toward zero, then clamps at zero and saturates at 64 bits.
	function automatic rtt_stats_t advance_rtt_stats(input rrs_pkg::rtt_t x);
		logic [127:0]        cnt_w;
		logic [127:0]        acc;
		logic [127:0]        prod;
		rrs_pkg::mean_t      x_q16;
		rrs_pkg::mean_t      mean_next;
		rrs_pkg::mean_t      dev_old;
		rrs_pkg::mean_t      dev_new;
		logic                below_old;
		logic                below_new;
		logic signed [129:0] p_s;
		logic signed [129:0] v_s;
		logic signed [129:0] n_s;
		logic signed [129:0] nv_s;
		rtt_stats_t          res;

		x_q16 = {x, 16'd0};
		if (x < min_seen) begin
			min_seen = x;
		end
		if (x > max_seen) begin
			max_seen = x;
		end

		cnt_w = 128'(count_seen);
		acc = cnt_w * 128'(mean_acc) + 128'(x_q16);
		mean_next = rrs_pkg::mean_t'(acc / (cnt_w + 128'd1));

		if (count_seen == '0) begin
			// First sample: no spread yet
			var_acc = '0;
		end else begin
			below_old = x_q16 < mean_acc;
			below_new = x_q16 < mean_next;
			dev_old = below_old ? mean_acc - x_q16 : x_q16 - mean_acc;
			dev_new = below_new ? mean_next - x_q16 : x_q16 - mean_next;
			prod = 128'(dev_old) * 128'(dev_new);
			// Drop the 32 fraction bits of the Q64.32 product, then apply the sign
			p_s = $signed({66'd0, prod[95:32]});
			if (below_old != below_new) begin
				p_s = -p_s;
			end
			v_s = $signed({66'd0, var_acc});
			n_s = $signed({98'd0, count_seen});
			nv_s = v_s + (p_s - v_s) / n_s;
			if (nv_s < 0) begin
				var_acc = '0;
			end else if (nv_s[129:64] != '0) begin
				var_acc = '1;
			end else begin
				var_acc = nv_s[63:0];
			end
		end

		mean_acc = mean_next;
		// The count sticks at all ones; later updates keep using that count
		if (count_seen != '1) begin
			count_seen = count_seen + 1'b1;
		end

		res.min_us       = min_seen;
		res.max_us       = max_seen;
		res.mean_q16     = mean_acc;
		res.variance_us2 = var_acc;
		res.sample_count = count_seen;
		return res;
	endfunction

	// Draw a sample from a mix of realistic link delays and corner values.
	function automatic rrs_pkg::rtt_t pick_rtt();
		int unsigned kind;
		kind = $urandom_range(0, 99);
		if (kind < 45) begin
			return rrs_pkg::rtt_t'($urandom_range(800, 1200));
		end else if (kind < 65) begin
			return rrs_pkg::rtt_t'($urandom_range(0, 500000));
		end else if (kind < 80) begin
			return rrs_pkg::rtt_t'($urandom());
		end else if (kind < 88) begin
			// Walking one or walking zero
			if ($urandom_range(0, 1) == 0) begin
				return rrs_pkg::rtt_t'(1) << $urandom_range(0, rrs_pkg::RttW - 1);
			end
			return ~(rrs_pkg::rtt_t'(1) << $urandom_range(0, rrs_pkg::RttW - 1));
		end else if (kind < 94) begin
			return ($urandom_range(0, 1) == 0) ? '0 : '1;
		end
		return rrs_pkg::rtt_t'($urandom_range(0, 15));
	endfunction

	// Offer one sample request, optionally after a random gap, and hold it until accepted.
	// Keep valid high when no gap follows, so back-to-back requests never glitch it.
	task automatic send_sample(input rrs_pkg::rtt_t x);
		int unsigned gap;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (steady_flow || pick < 60) begin
			gap = 0;
		end else if (pick < 95) begin
			gap = $urandom_range(1, 8);
		end else begin
			gap = $urandom_range(20, 250);
		end
		if (gap != 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid  <= 1'b1;
		sample_ch.rtt_us <= x;
		do @(posedge clk); while (sample_ch.ready !== 1'b1);
		expected_stats_q.push_back(advance_rtt_stats(x));
	endtask

	task automatic check_field(input string field, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
			error_count++;
		end
	endtask

	// First sample after reset: the variance phases are skipped and the variance is zero.
	task automatic test_first_sample();
		send_sample(32'd1250);
	endtask

	// Zero, full scale and half scale: min and max extremes and the largest spread.
	task automatic test_full_scale();
		rrs_pkg::rtt_t corner[8];
		corner = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
			32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFE, 32'h8000_0000};
		foreach (corner[i]) begin
			send_sample(corner[i]);
		end
	endtask

	// A run of equal samples with no idling on either side: the spread shrinks toward zero.
	task automatic test_steady_samples();
		steady_flow = 1'b1;
		repeat (6) send_sample(32'd1250);
		steady_flow = 1'b0;
	endtask

	// Hold the output off for a long stretch while samples keep coming, so one result
	// waits, the next sample is taken in, and the block then stalls its input.
	task automatic test_output_stall();
		steady_flow = 1'b1;
		hold_start <= 1'b1;
		@(posedge clk);
		hold_start <= 1'b0;
		repeat (PressureSamples) send_sample(pick_rtt());
		steady_flow = 1'b0;
	endtask

	task automatic test_random_samples();
		repeat (RandomSamples) send_sample(pick_rtt());
	endtask

	// Count the long hold-off down in its own process.
	always @(posedge clk) begin
		if (hold_start) begin
			hold_left <= HoldCycles;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Receiver: check every accepted statistics request against the oldest expectation,
	// then decide ready for the next cycle (hold-off, short stalls, rare long stalls).
	initial begin
		int unsigned stall_left;
		int unsigned pick;
		rtt_stats_t  want;

		stall_left = 0;
		stats_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && stats_ch.valid && stats_ch.ready) begin
				if (expected_stats_q.size() == 0) begin
					$display("%0t: statistics request with no sample outstanding, actual count %0d",
						$time, stats_ch.sample_count);
					error_count++;
				end else begin
					want = expected_stats_q.pop_front();
					check_field("min_us", 64'(want.min_us), 64'(stats_ch.min_us));
					check_field("max_us", 64'(want.max_us), 64'(stats_ch.max_us));
					check_field("mean_q16", 64'(want.mean_q16), 64'(stats_ch.mean_q16));
					check_field("variance_us2", want.variance_us2, stats_ch.variance_us2);
					check_field("sample_count", 64'(want.sample_count),
						64'(stats_ch.sample_count));
				end
			end

			if (!arst_n || hold_start || hold_left != 0) begin
				stats_ch.ready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left--;
				stats_ch.ready <= 1'b0;
			end else begin
				pick = $urandom_range(0, 999);
				if (!steady_flow && pick < 100) begin
					stall_left = $urandom_range(0, 3);
					stats_ch.ready <= 1'b0;
				end else if (!steady_flow && pick == 100) begin
					stall_left = $urandom_range(20, 300);
					stats_ch.ready <= 1'b0;
				end else begin
					stats_ch.ready <= 1'b1;
				end
			end
		end
	end

	// Watchdog: end the run if the block hangs.
	initial begin
		while (cycle_count < CycleLimit) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		arst_n           <= 1'b0;
		sample_ch.valid  <= 1'b0;
		sample_ch.rtt_us <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_first_sample();
		test_full_scale();
		test_steady_samples();
		test_output_stall();
		test_random_samples();

		// Drop the last request, drain the expectations, then watch for strays
		sample_ch.valid <= 1'b0;
		while (expected_stats_q.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

/* running_rtt_statistics.f */
hw/rtl/rrs_pkg.sv
hw/rtl/rrs_if.sv
hw/rtl/running_rtt_statistics.sv
verif/tb_top.sv
